// File: rtl/silu_fb_pkg.sv
// ----------------------------------------------------------------------------
// silu_fb_pkg: shared types and constants of the SiLU forward/backward unit
// Transfer structs, the operation code, the exp(-r/256) table and the pipeline
// sizing constants.
// ----------------------------------------------------------------------------
package silu_fb_pkg;

  // operation code
  typedef enum logic {
    OP_FORWARD  = 1'b0,
    OP_BACKWARD = 1'b1
  } silu_fb_op_e;

  // one input transfer
  typedef struct packed {
    silu_fb_op_e        operation;
    logic signed [15:0] sample_x;
    logic signed [15:0] upstream_grad;
    logic signed [15:0] prior_grad;
  } silu_fb_in_t;

  // one result transfer
  typedef struct packed {
    logic signed [15:0] result;
    logic               saturated;
  } silu_fb_out_t;

  // sigmoid argument clamp, 88.0 in Q8.8
  localparam logic [15:0] SigClamp = 16'd22528;

  // integer part of the argument from which the sigmoid is fully settled
  localparam logic [6:0] BigQnt = 7'd12;

  // exp(-1) multiply stages, enough for every unsettled argument
  localparam int MulStages = 11;

  // sigmoid divider: quotient width and quotient bits per stage
  localparam int QuoW      = 17;
  localparam int DivBits   = 2;
  localparam int DivStages = (QuoW + DivBits - 1) / DivBits;

  // cycles from input transfer to result strobe
  localparam int Latency = MulStages + DivStages + 9;

  // largest sigmoid code
  localparam logic [15:0] SigMax = 16'hFFFF;

  // Q0.32 product rounded half up
  function automatic logic [32:0] mul_q32(logic [32:0] a, logic [31:0] b);
    logic [64:0] p;
    p = a * b + 65'h0_8000_0000;
    return p[64:32];
  endfunction

  // one truncated series step, before the divide by the term index
  function automatic logic [63:0] taylor_step(logic [63:0] term, logic [63:0] t);
    return (term * t) >> 32;
  endfunction

  // exp(-r/256) in Q0.32 by an alternating series up to the 24th power
  function automatic logic [32:0] exp_frac(logic [7:0] r);
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] sum;
    t    = {32'b0, r, 24'b0};
    term = 64'h1_0000_0000;
    sum  = term;
    term = taylor_step(term, t) / 64'd1;  sum = sum - term;
    term = taylor_step(term, t) / 64'd2;  sum = sum + term;
    term = taylor_step(term, t) / 64'd3;  sum = sum - term;
    term = taylor_step(term, t) / 64'd4;  sum = sum + term;
    term = taylor_step(term, t) / 64'd5;  sum = sum - term;
    term = taylor_step(term, t) / 64'd6;  sum = sum + term;
    term = taylor_step(term, t) / 64'd7;  sum = sum - term;
    term = taylor_step(term, t) / 64'd8;  sum = sum + term;
    term = taylor_step(term, t) / 64'd9;  sum = sum - term;
    term = taylor_step(term, t) / 64'd10; sum = sum + term;
    term = taylor_step(term, t) / 64'd11; sum = sum - term;
    term = taylor_step(term, t) / 64'd12; sum = sum + term;
    term = taylor_step(term, t) / 64'd13; sum = sum - term;
    term = taylor_step(term, t) / 64'd14; sum = sum + term;
    term = taylor_step(term, t) / 64'd15; sum = sum - term;
    term = taylor_step(term, t) / 64'd16; sum = sum + term;
    term = taylor_step(term, t) / 64'd17; sum = sum - term;
    term = taylor_step(term, t) / 64'd18; sum = sum + term;
    term = taylor_step(term, t) / 64'd19; sum = sum - term;
    term = taylor_step(term, t) / 64'd20; sum = sum + term;
    term = taylor_step(term, t) / 64'd21; sum = sum - term;
    term = taylor_step(term, t) / 64'd22; sum = sum + term;
    term = taylor_step(term, t) / 64'd23; sum = sum - term;
    term = taylor_step(term, t) / 64'd24; sum = sum + term;
    return sum[32:0];
  endfunction

  typedef logic [255:0][32:0] exp_tab_t;

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = exp_frac(8'(i));
    end
    return tab;
  endfunction

  // exp(-r/256) for the fractional part of the argument
  localparam exp_tab_t ExpFracTab = build_exp_tab();

  // exp(-1) as exp(-1/2) squared
  localparam logic [32:0] ExpNegHalfW = exp_frac(8'd128);
  localparam logic [31:0] ExpNegHalf  = ExpNegHalfW[31:0];
  localparam logic [32:0] ExpNegOneW  = mul_q32({1'b0, ExpNegHalf}, ExpNegHalf);
  localparam logic [31:0] ExpNegOne   = ExpNegOneW[31:0];

endpackage

// File: rtl/silu_forward_backward.sv
// ----------------------------------------------------------------------------
// silu_forward_backward: elementwise SiLU, forward and gradient accumulate
// Fully pipelined: one element per clock, fixed latency, no back-pressure.
// ----------------------------------------------------------------------------
// A sample is taken on every clock edge with start high; busy is always low,
// so the unit accepts one element per cycle without gaps. Each result shows
// on out_o with result_valid_o high for one cycle, in input order, after it
// has passed the pipeline, whose bulk is the chain of eleven exp(-1) multiply
// stages and the nine-stage restoring divider that forms the sigmoid; the
// receiver must take every strobed result.
module silu_forward_backward (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  silu_fb_pkg::silu_fb_in_t  in_i,
  output logic                      result_valid_o,
  output silu_fb_pkg::silu_fb_out_t out_o
);
  import silu_fb_pkg::*;

  // never stalls
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // stage A: clamp |x| and split into integer and fractional parts
  // --------------------------------------------------------------------------
  logic        sa_vld_q;
  silu_fb_in_t sa_item_q;
  logic [6:0]  sa_qnt_q, sa_qnt_d;
  logic [7:0]  sa_frac_q, sa_frac_d;
  logic        sa_big_q, sa_big_d;

  logic [15:0] abs_x;
  logic [15:0] clamp_x;

  always_comb begin
    abs_x     = in_i.sample_x[15] ? 16'(-in_i.sample_x) : in_i.sample_x;
    clamp_x   = (in_i.sample_x == 16'sh8000 || abs_x > SigClamp) ? SigClamp : abs_x;
    sa_qnt_d  = clamp_x[14:8];
    sa_frac_d = clamp_x[7:0];
    sa_big_d  = (clamp_x[14:8] >= BigQnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else begin
      sa_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_item_q <= in_i;
    sa_qnt_q  <= sa_qnt_d;
    sa_frac_q <= sa_frac_d;
    sa_big_q  <= sa_big_d;
  end

  // --------------------------------------------------------------------------
  // stage B and multiply chain: e = exp(-frac/256) * exp(-1)^qnt
  // --------------------------------------------------------------------------
  logic        m_vld_q  [MulStages+1];
  silu_fb_in_t m_item_q [MulStages+1];
  logic [32:0] m_e_q    [MulStages+1];
  logic [6:0]  m_qnt_q  [MulStages+1];
  logic        m_big_q  [MulStages+1];

  // table lookup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q[0] <= 1'b0;
    end else begin
      m_vld_q[0] <= sa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_item_q[0] <= sa_item_q;
    m_e_q[0]    <= ExpFracTab[sa_frac_q];
    m_qnt_q[0]  <= sa_qnt_q;
    m_big_q[0]  <= sa_big_q;
  end

  // one rounded exp(-1) multiply per stage while the count asks for it
  for (genvar k = 1; k <= MulStages; k++) begin : g_mul
    logic [32:0] e_d;

    assign e_d = (m_qnt_q[k-1] >= 7'(k)) ? mul_q32(m_e_q[k-1], ExpNegOne)
                                         : m_e_q[k-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m_vld_q[k] <= 1'b0;
      end else begin
        m_vld_q[k] <= m_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      m_item_q[k] <= m_item_q[k-1];
      m_e_q[k]    <= e_d;
      m_qnt_q[k]  <= m_qnt_q[k-1];
      m_big_q[k]  <= m_big_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // divider set-up: denominator 1 + e, numerator with half-up rounding
  // --------------------------------------------------------------------------
  logic        dv_vld_q  [DivStages+1];
  silu_fb_in_t dv_item_q [DivStages+1];
  logic        dv_big_q  [DivStages+1];
  logic [33:0] dv_den_q  [DivStages+1];
  logic [50:0] dv_rem_q  [DivStages+1];
  logic [16:0] dv_quo_q  [DivStages+1];

  logic [32:0] e_fin;
  logic [33:0] den_d;
  logic [50:0] num_d;

  always_comb begin
    e_fin = m_e_q[MulStages];
    den_d = 34'h1_0000_0000 + {1'b0, e_fin};
    if (!m_item_q[MulStages].sample_x[15]) begin
      num_d = {2'b0, 1'b1, 48'b0} + {18'b0, den_d[33:1]};
    end else begin
      num_d = {2'b0, e_fin, 16'b0} + {18'b0, den_d[33:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= m_vld_q[MulStages];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_item_q[0] <= m_item_q[MulStages];
    dv_big_q[0]  <= m_big_q[MulStages];
    dv_den_q[0]  <= den_d;
    dv_rem_q[0]  <= num_d;
    dv_quo_q[0]  <= '0;
  end

  // restoring division, a couple of quotient bits per stage, msb first
  for (genvar j = 1; j <= DivStages; j++) begin : g_div
    logic [50:0] rem_d;
    logic [16:0] quo_d;

    always_comb begin
      logic [50:0] rem;
      logic [16:0] quo;
      logic [50:0] dsh;
      int          idx;
      rem = dv_rem_q[j-1];
      quo = dv_quo_q[j-1];
      dsh = '0;
      idx = 0;
      for (int b = 0; b < DivBits; b++) begin
        idx = QuoW - 1 - (j - 1) * DivBits - b;
        if (idx >= 0) begin
          dsh = {17'b0, dv_den_q[j-1]} << idx;
          if (rem >= dsh) begin
            rem             = rem - dsh;
            quo[idx[4:0]]   = 1'b1;
          end
        end
      end
      rem_d = rem;
      quo_d = quo;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j] <= 1'b0;
      end else begin
        dv_vld_q[j] <= dv_vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_item_q[j] <= dv_item_q[j-1];
      dv_big_q[j]  <= dv_big_q[j-1];
      dv_den_q[j]  <= dv_den_q[j-1];
      dv_rem_q[j]  <= rem_d;
      dv_quo_q[j]  <= quo_d;
    end
  end

  // --------------------------------------------------------------------------
  // sigmoid: saturate, settled values for large arguments
  // --------------------------------------------------------------------------
  logic        ss_vld_q;
  silu_fb_in_t ss_item_q;
  logic [15:0] ss_sig_q, ss_sig_d;

  always_comb begin
    if (dv_big_q[DivStages]) begin
      ss_sig_d = dv_item_q[DivStages].sample_x[15] ? 16'h0000 : SigMax;
    end else if (dv_quo_q[DivStages][16]) begin
      ss_sig_d = SigMax;
    end else begin
      ss_sig_d = dv_quo_q[DivStages][15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_vld_q <= 1'b0;
    end else begin
      ss_vld_q <= dv_vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    ss_item_q <= dv_item_q[DivStages];
    ss_sig_q  <= ss_sig_d;
  end

  // --------------------------------------------------------------------------
  // P1: x*s and g*s
  // --------------------------------------------------------------------------
  logic               p1_vld_q;
  silu_fb_in_t        p1_item_q;
  logic signed [32:0] p1_xs_q, p1_xs_d;
  logic signed [32:0] p1_gs_q, p1_gs_d;

  always_comb begin
    p1_xs_d = $signed(ss_item_q.sample_x) * $signed({1'b0, ss_sig_q});
    p1_gs_d = $signed(ss_item_q.upstream_grad) * $signed({1'b0, ss_sig_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= ss_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_item_q <= ss_item_q;
    p1_xs_q   <= p1_xs_d;
    p1_gs_q   <= p1_gs_d;
  end

  // --------------------------------------------------------------------------
  // P2: forward rounding, backward factor 1 + x*(1 - s) in Q.24
  // --------------------------------------------------------------------------
  logic               p2_vld_q;
  silu_fb_in_t        p2_item_q;
  logic signed [15:0] p2_fwd_q, p2_fwd_d;
  logic signed [33:0] p2_fac_q, p2_fac_d;
  logic signed [32:0] p2_gs_q;

  logic signed [32:0] fwd_sum;
  logic signed [33:0] x_up;

  always_comb begin
    // round half up, then floor shift
    fwd_sum  = p1_xs_q + 33'sd32768;
    p2_fwd_d = fwd_sum[31:16];
    x_up     = {{2{p1_item_q.sample_x[15]}}, p1_item_q.sample_x, 16'b0};
    p2_fac_d = 34'sh000_0100_0000 + x_up - {p1_xs_q[32], p1_xs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_item_q <= p1_item_q;
    p2_fwd_q  <= p2_fwd_d;
    p2_fac_q  <= p2_fac_d;
    p2_gs_q   <= p1_gs_q;
  end

  // --------------------------------------------------------------------------
  // P3: partial products of (g*s) * factor
  // --------------------------------------------------------------------------
  logic               p3_vld_q;
  silu_fb_in_t        p3_item_q;
  logic signed [15:0] p3_fwd_q;
  logic signed [50:0] p3_lo_q, p3_lo_d;
  logic signed [49:0] p3_hi_q, p3_hi_d;

  always_comb begin
    p3_lo_d = p2_gs_q * $signed({1'b0, p2_fac_q[16:0]});
    p3_hi_d = p2_gs_q * $signed(p2_fac_q[33:17]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_item_q <= p2_item_q;
    p3_fwd_q  <= p2_fwd_q;
    p3_lo_q   <= p3_lo_d;
    p3_hi_q   <= p3_hi_d;
  end

  // --------------------------------------------------------------------------
  // P4: combine partial products into the Q.48 gradient term
  // --------------------------------------------------------------------------
  logic               p4_vld_q;
  silu_fb_in_t        p4_item_q;
  logic signed [15:0] p4_fwd_q;
  logic signed [66:0] p4_prod_q, p4_prod_d;

  always_comb begin
    p4_prod_d = {{17{p3_hi_q[49]}}, p3_hi_q} * 67'sd131072
              + {{16{p3_lo_q[50]}}, p3_lo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_vld_q <= 1'b0;
    end else begin
      p4_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p4_item_q <= p3_item_q;
    p4_fwd_q  <= p3_fwd_q;
    p4_prod_q <= p4_prod_d;
  end

  // --------------------------------------------------------------------------
  // output: round the term, accumulate, saturate, select by operation
  // --------------------------------------------------------------------------
  logic         out_vld_q;
  silu_fb_out_t out_q, out_d;

  logic signed [66:0] prod_rnd;
  logic signed [26:0] grad_term;
  logic signed [27:0] grad_sum;

  always_comb begin
    prod_rnd  = p4_prod_q + {27'b0, 1'b1, 39'b0};
    grad_term = prod_rnd[66:40];
    grad_sum  = {{12{p4_item_q.prior_grad[15]}}, p4_item_q.prior_grad}
              + {grad_term[26], grad_term};
    out_d     = '0;
    case (p4_item_q.operation)
      OP_FORWARD: begin
        out_d.result    = p4_fwd_q;
        out_d.saturated = 1'b0;
      end
      OP_BACKWARD: begin
        if (grad_sum > 28'sd32767) begin
          out_d.result    = 16'sh7FFF;
          out_d.saturated = 1'b1;
        end else if (grad_sum < -28'sd32768) begin
          out_d.result    = 16'sh8000;
          out_d.saturated = 1'b1;
        end else begin
          out_d.result    = grad_sum[15:0];
          out_d.saturated = 1'b0;
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= p4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = out_vld_q;
  assign out_o          = out_q;

endmodule

// File: rtl/silu_fb_checker.sv
// ----------------------------------------------------------------------------
// silu_fb_checker: port-level checks of the SiLU unit
// Fixed latency, no back-pressure and saturation flag consistency.
// ----------------------------------------------------------------------------
module silu_fb_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      result_valid_o,
  input silu_fb_pkg::silu_fb_out_t out_o
);
  import silu_fb_pkg::*;

  // the unit never holds off a transfer
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // every accepted sample gives a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency result_valid_o)
    else $error("result missing after accepted sample");

  // no result without an accepted sample the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, Latency))
    else $error("result without matching sample");

  // a saturated result sits on a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_o.saturated) |->
      (out_o.result == 16'sh7FFF || out_o.result == 16'sh8000))
    else $error("saturation flag with in-range result");

endmodule

bind silu_forward_backward silu_fb_checker u_silu_fb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .out_o          (out_o)
);

// File: sim/silu_forward_backward_check.sv
// ----------------------------------------------------------------------------
// silu_forward_backward_check: result checker for the SiLU forward/backward unit
// Watches the command and result channels, works out the expected result of
// every accepted sample with an independent fixed-point sigmoid, and compares
// each strobed result field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module silu_forward_backward_check
  import silu_fb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         busy_i,
  input  silu_fb_in_t  in_i,
  input  logic         result_valid_i,
  input  silu_fb_out_t out_i,
  output int           fail_count_o,
  output int           outstanding_o
);

  // 88.0 in Q8.8, limit of the sigmoid argument
  localparam logic [63:0] ArgLimit = 64'd22528;
  localparam logic [63:0] OneQ32   = 64'h1_0000_0000;

  silu_fb_out_t expected_q[$];
  silu_fb_out_t oldest;
  int           fail_count  = 0;
  int           outstanding = 0;

  assign fail_count_o  = fail_count;
  assign outstanding_o = outstanding;

  // exp(-r/256) in Q0.32, alternating series of 24 truncated terms
  function automatic logic [63:0] exp_neg_fraction(logic [7:0] r);
    logic [63:0] arg;
    logic [63:0] term;
    logic [63:0] acc;
    arg  = {32'd0, r, 24'd0};
    term = OneQ32;
    acc  = OneQ32;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * arg) >> 32) / 64'(n);
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  // Q0.32 product, rounded half up
  function automatic logic [63:0] round_q32(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'h8000_0000) >> 32;
  endfunction

  // sigmoid of a Q8.8 sample as an unsigned Q0.16 code
  function automatic logic [15:0] sigmoid_code(logic signed [15:0] x);
    logic [63:0] mag;
    logic [63:0] exp_neg_one;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] quo;
    mag = (x < 0) ? 64'(-int'(x)) : 64'(int'(x));
    if (mag > ArgLimit) begin
      mag = ArgLimit;
    end
    // exp(-1) as exp(-1/2) squared
    exp_neg_one = exp_neg_fraction(8'd128);
    exp_neg_one = round_q32(exp_neg_one, exp_neg_one);
    e = exp_neg_fraction(mag[7:0]);
    for (int i = 0; i < int'(mag >> 8); i++) begin
      e = round_q32(e, exp_neg_one);
    end
    den = OneQ32 + e;
    if (x >= 0) begin
      quo = ((64'd1 << 48) + den / 2) / den;
    end else begin
      quo = ((e << 16) + den / 2) / den;
    end
    // 1.0 has no code, so the top saturates
    if (quo > 64'd65535) begin
      quo = 64'd65535;
    end
    return quo[15:0];
  endfunction

  // forward silu or backward gradient accumulate for one sample
  function automatic silu_fb_out_t predict_result(silu_fb_in_t item);
    silu_fb_out_t res;
    logic [15:0]  s;
    longint       factor;
    longint       prod;
    longint       acc;
    s   = sigmoid_code(item.sample_x);
    res = '0;
    if (item.operation == OP_FORWARD) begin
      prod       = longint'(item.sample_x) * longint'(s);
      acc        = (prod + 64'sd32768) >>> 16;
      res.result = acc[15:0];
    end else begin
      // 1 + x*(1-s) in Q.24, the product in Q.48
      factor = (longint'(1) << 24) + longint'(item.sample_x) * (65536 - longint'(s));
      prod   = longint'(item.upstream_grad) * (longint'(s) * factor);
      acc    = longint'(item.prior_grad) + ((prod + (longint'(1) << 39)) >>> 40);
      if (acc > 32767) begin
        acc           = 32767;
        res.saturated = 1'b1;
      end else if (acc < -32768) begin
        acc           = -32768;
        res.saturated = 1'b1;
      end
      res.result = acc[15:0];
    end
    return res;
  endfunction

  // compare strobed results, then queue the prediction of a new transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %0d saturated %0b", $time, out_i.result,
                   out_i.saturated);
          fail_count++;
        end else begin
          oldest = expected_q.pop_front();
          if (out_i.result !== oldest.result) begin
            $display("%0t: result mismatch, expected %0d got %0d", $time,
                     oldest.result, out_i.result);
            fail_count++;
          end
          if (out_i.saturated !== oldest.saturated) begin
            $display("%0t: saturated mismatch, expected %0b got %0b", $time,
                     oldest.saturated, out_i.saturated);
            fail_count++;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_q.push_back(predict_result(in_i));
      end
      outstanding = expected_q.size();
    end
  end

endmodule

// File: sim/silu_forward_backward_test.sv
// ----------------------------------------------------------------------------
// silu_forward_backward_test: testbench of the SiLU forward/backward unit
// Drives directed corner samples and then random bursts of forward and
// backward samples with random gaps; the checker beside the unit predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module silu_forward_backward_test;
  import silu_fb_pkg::*;

  localparam int RandomItems = 750;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 100000;

  logic         clk_i;
  logic         rst_ni;
  logic         start;
  logic         busy;
  silu_fb_in_t  in_i;
  logic         result_valid;
  silu_fb_out_t out_o;
  int           fail_count;
  int           outstanding;
  int           cycle_count = 0;

  silu_forward_backward uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid),
    .out_o          (out_o)
  );

  silu_forward_backward_check result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .in_i           (in_i),
    .result_valid_i (result_valid),
    .out_i          (out_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic silu_fb_in_t make_item(silu_fb_op_e op, logic [15:0] x,
                                            logic [15:0] grad, logic [15:0] prior);
    silu_fb_in_t item;
    item.operation     = op;
    item.sample_x      = x;
    item.upstream_grad = grad;
    item.prior_grad    = prior;
    return item;
  endfunction

  // mix of full-range, small, near-clamp and near-zero samples
  function automatic silu_fb_in_t random_item();
    silu_fb_in_t        item;
    logic signed [15:0] mag;
    item.operation = silu_fb_op_e'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: item.sample_x = 16'($urandom);
      1: item.sample_x = 16'($urandom_range(0, 4095)) - 16'd2048;
      2: begin
        mag           = 16'($urandom_range(21504, 24576));
        item.sample_x = $urandom_range(0, 1) ? -mag : mag;
      end
      default: item.sample_x = 16'($urandom_range(0, 511)) - 16'd256;
    endcase
    if ($urandom_range(0, 1)) begin
      item.upstream_grad = 16'($urandom);
      item.prior_grad    = 16'($urandom);
    end else begin
      item.upstream_grad = 16'($urandom_range(0, 2047)) - 16'd1024;
      item.prior_grad    = 16'($urandom_range(0, 2047)) - 16'd1024;
    end
    return item;
  endfunction

  // offer one sample and hold it until the transfer
  task automatic push_item(input silu_fb_in_t item);
    @(negedge clk_i);
    start <= 1'b1;
    in_i  <= item;
    do @(posedge clk_i); while (busy);
  endtask

  // idle cycles with noise on the payload
  task automatic idle_gap(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
      in_i  <= random_item();
    end
  endtask

  initial begin
    int sent;
    int burst;
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    start  = 1'b0;
    in_i   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_gap(2);

    // forward corners; gradient fields carry junk that must be ignored
    push_item(make_item(OP_FORWARD, 16'sd0, 16'h7FFF, 16'h8000));
    push_item(make_item(OP_FORWARD, 16'sd1, 16'h8000, 16'h7FFF));
    push_item(make_item(OP_FORWARD, -16'sd1, 16'hFFFF, 16'hFFFF));
    push_item(make_item(OP_FORWARD, 16'sd32767, 16'h1234, 16'hABCD));
    push_item(make_item(OP_FORWARD, -16'sd32768, 16'h5555, 16'hAAAA));
    push_item(make_item(OP_FORWARD, 16'sd22528, 16'h0, 16'h0));
    push_item(make_item(OP_FORWARD, -16'sd22528, 16'h0, 16'h0));
    push_item(make_item(OP_FORWARD, 16'sd22529, 16'h0, 16'h0));
    push_item(make_item(OP_FORWARD, -16'sd22529, 16'h0, 16'h0));
    push_item(make_item(OP_FORWARD, 16'sd256, 16'h0, 16'h0));
    push_item(make_item(OP_FORWARD, -16'sd256, 16'h0, 16'h0));
    // sigmoid pinned at its top code, then near zero for the negative sample
    push_item(make_item(OP_FORWARD, 16'sd3200, 16'h0, 16'h0));
    push_item(make_item(OP_FORWARD, -16'sd3000, 16'h0, 16'h0));
    idle_gap(3);

    // backward corners, both saturation directions
    push_item(make_item(OP_BACKWARD, 16'sd0, 16'sd256, 16'sd0));
    push_item(make_item(OP_BACKWARD, 16'sd32767, 16'sd32767, 16'sd32767));
    push_item(make_item(OP_BACKWARD, 16'sd32767, -16'sd32768, -16'sd32768));
    push_item(make_item(OP_BACKWARD, 16'sd512, -16'sd32768, -16'sd32768));
    push_item(make_item(OP_BACKWARD, -16'sd32768, 16'sd32767, -16'sd32768));
    push_item(make_item(OP_BACKWARD, -16'sd512, -16'sd32768, 16'sd32767));
    push_item(make_item(OP_BACKWARD, 16'sd22529, 16'sd1, 16'sd0));
    push_item(make_item(OP_BACKWARD, 16'sd3000, -16'sd256, 16'sd100));
    push_item(make_item(OP_BACKWARD, -16'sd22529, 16'sd32767, 16'sd32767));
    idle_gap(4);

    // random bursts, some back to back with no gap
    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RandomItems; k++) begin
        push_item(random_item());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_gap($urandom_range(1, 6));
      end
    end
    idle_gap(1);

    // drain the pipeline
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: silu_forward_backward.f
rtl/silu_fb_pkg.sv
rtl/silu_forward_backward.sv
rtl/silu_fb_checker.sv
sim/silu_forward_backward_check.sv
sim/silu_forward_backward_test.sv
